[hw/rtl/stt_pkg.sv]
package stt_pkg;

    localparam int DEF_INDEX_BITS = 12;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_MATE_THR  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATED_THR = 2'd1;

    localparam logic [14:0]        MATE_THR_RST  = 15'd31000;
    localparam logic signed [15:0] MATED_THR_RST = -16'sd31000;

    typedef enum logic [1:0] {
        CMD_PROBE   = 2'd0,
        CMD_STORE   = 2'd1,
        CMD_NEW_GEN = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    // decoded word handed from front to back
    typedef struct packed {
        t_cmd               cmd;
        logic [63:0]        key;
        logic [15:0]        move;
        logic signed [15:0] score;
        logic [7:0]         depth;
        logic [1:0]         flag;
        logic [7:0]         ply;
    } t_item;

    typedef struct packed {
        logic [63:0]        tag;
        logic [7:0]         age;
        logic [1:0]         flag;
        logic [7:0]         depth;
        logic signed [15:0] score;
        logic [15:0]        move;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic sweeping;
    } t_back_status;

    // mate score shift by ply, saturating to 16 bits
    function automatic logic signed [15:0] adjust_score(
        input logic signed [15:0] s,
        input logic [7:0]         ply,
        input logic               to_table,
        input logic [14:0]        mate_thr,
        input logic signed [15:0] mated_thr
    );
        logic signed [16:0] sx;
        logic signed [16:0] px;
        logic signed [16:0] sum;
        logic signed [15:0] res;
        sx = {s[15], s};
        px = {9'b0, ply};
        if (sx >= $signed({2'b00, mate_thr})) begin
            sum = to_table ? sx + px : sx - px;
        end else if (s <= mated_thr) begin
            sum = to_table ? sx - px : sx + px;
        end else begin
            sum = sx;
        end
        if (sum > 17'sd32767) begin
            res = 16'sh7FFF;
        end else if (sum < -17'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = sum[15:0];
        end
        return res;
    endfunction

endpackage

[hw/rtl/search_transposition_table_core.sv]
// a word goes from the input queue into the item register with its table ram read,
//   and its result into the output register, held while that register is full; the
//   back takes no new word until the last has left its exec state
// clear zeroes the whole table, one table entry zeroed per cycle, then gives a result
// reset: synchronous, active low; afterwards a zeroing sweep over all 2^INDEX_BITS
//   entries runs with o_in_ready low, config writes are taken throughout
module search_transposition_table_core #(
    parameter int INDEX_BITS = stt_pkg::DEF_INDEX_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [stt_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [stt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_command,
    input  logic [63:0]                      i_key,
    input  logic [15:0]                      i_best_move,
    input  logic signed [15:0]               i_score,
    input  logic [7:0]                       i_search_depth,
    input  logic [1:0]                       i_bound_flag,
    input  logic [7:0]                       i_ply,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_hit,
    output logic [15:0]                      o_hit_move,
    output logic signed [15:0]               o_hit_score,
    output logic [7:0]                       o_hit_depth,
    output logic [1:0]                       o_hit_flag,
    output logic                             o_stored
);
    import stt_pkg::*;

    logic [14:0]        r_mate_thr;
    logic signed [15:0] r_mated_thr;
    logic               head_valid;
    t_item              head;
    logic               pop;
    t_back_status       back_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mate_thr  <= MATE_THR_RST;
            r_mated_thr <= MATED_THR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MATE_THR:  r_mate_thr  <= i_cfg_data[14:0];
                CFG_MATED_THR: r_mated_thr <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    stt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_key          (i_key),
        .i_best_move    (i_best_move),
        .i_score        (i_score),
        .i_search_depth (i_search_depth),
        .i_bound_flag   (i_bound_flag),
        .i_ply          (i_ply),
        .i_mate_thr     (r_mate_thr),
        .i_mated_thr    (r_mated_thr),
        .i_back_status  (back_status),
        .o_head_valid   (head_valid),
        .o_head         (head),
        .i_pop          (pop)
    );

    stt_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mate_thr   (r_mate_thr),
        .i_mated_thr  (r_mated_thr),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_status     (back_status),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hit        (o_hit),
        .o_hit_move   (o_hit_move),
        .o_hit_score  (o_hit_score),
        .o_hit_depth  (o_hit_depth),
        .o_hit_flag   (o_hit_flag),
        .o_stored     (o_stored)
    );

endmodule

[hw/rtl/stt_ram.sv]
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/stt_front.sv]
module stt_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_command,
    input  logic [63:0]          i_key,
    input  logic [15:0]          i_best_move,
    input  logic signed [15:0]   i_score,
    input  logic [7:0]           i_search_depth,
    input  logic [1:0]           i_bound_flag,
    input  logic [7:0]           i_ply,
    input  logic [14:0]          i_mate_thr,
    input  logic signed [15:0]   i_mated_thr,
    input  stt_pkg::t_back_status i_back_status,
    output logic                 o_head_valid,
    output stt_pkg::t_item       o_head,
    input  logic                 i_pop
);
    import stt_pkg::*;

    t_item      r_queue [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;
    t_item      item;

    // decode and pre-shift the score for the table
    always_comb begin
        item.cmd   = t_cmd'(i_command);
        item.key   = i_key;
        item.move  = i_best_move;
        item.score = adjust_score(i_score, i_ply, 1'b1, i_mate_thr, i_mated_thr);
        item.depth = i_search_depth;
        item.flag  = i_bound_flag;
        item.ply   = i_ply;
    end

    assign o_in_ready   = (r_count != 2'd2) && !i_back_status.sweeping;
    assign push         = i_in_valid && o_in_ready;
    assign o_head_valid = (r_count != 2'd0);
    assign pop          = i_pop && o_head_valid;
    assign o_head       = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_queue[r_wr_ptr] <= item;
                r_wr_ptr          <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

[hw/rtl/stt_back.sv]
module stt_back #(
    parameter int INDEX_BITS = stt_pkg::DEF_INDEX_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [14:0]           i_mate_thr,
    input  logic signed [15:0]    i_mated_thr,
    input  logic                  i_head_valid,
    input  stt_pkg::t_item        i_head,
    output logic                  o_pop,
    output stt_pkg::t_back_status o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_hit,
    output logic [15:0]           o_hit_move,
    output logic signed [15:0]    o_hit_score,
    output logic [7:0]            o_hit_depth,
    output logic [1:0]            o_hit_flag,
    output logic                  o_stored
);
    import stt_pkg::*;

    localparam int DEPTH = 1 << INDEX_BITS;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                  r_state;
    logic [INDEX_BITS-1:0]   r_clr_idx;
    logic                    r_clr_pend;
    logic [7:0]              r_age;
    t_item                   r_item;
    logic                    r_out_valid;
    logic                    r_hit;
    logic [15:0]             r_hit_move;
    logic signed [15:0]      r_hit_score;
    logic [7:0]              r_hit_depth;
    logic [1:0]              r_hit_flag;
    logic                    r_stored;

    logic                    out_free;
    logic                    we;
    logic [INDEX_BITS-1:0]   waddr;
    logic [INDEX_BITS-1:0]   raddr;
    t_entry                  wentry;
    logic [ENTRY_W-1:0]      rdata;
    t_entry                  rentry;
    logic                    tag_hit;
    logic                    replace;
    logic                    n_hit;
    logic [15:0]             n_hit_move;
    logic signed [15:0]      n_hit_score;
    logic [7:0]              n_hit_depth;
    logic [1:0]              n_hit_flag;
    logic                    n_stored;

    stt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wentry),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign out_free          = !r_out_valid || i_out_ready;
    assign o_pop             = (r_state == S_IDLE) && i_head_valid;
    assign o_status.sweeping = (r_state == S_SWEEP);
    assign raddr = (r_state == S_IDLE) ? i_head.key[INDEX_BITS-1:0]
                                       : r_item.key[INDEX_BITS-1:0];
    assign rentry  = t_entry'(rdata);
    assign tag_hit = (rentry.tag == r_item.key);
    assign replace = (rentry.tag == 64'd0) || (rentry.age != r_age)
                   || (rentry.depth < r_item.depth);

    always_comb begin
        we          = 1'b0;
        waddr       = r_item.key[INDEX_BITS-1:0];
        wentry      = rentry;
        n_hit       = 1'b0;
        n_hit_move  = 16'd0;
        n_hit_score = 16'sd0;
        n_hit_depth = 8'd0;
        n_hit_flag  = 2'd0;
        n_stored    = 1'b0;
        unique case (r_state)
            S_SWEEP: begin
                we     = 1'b1;
                waddr  = r_clr_idx;
                wentry = '0;
            end
            S_EXEC: begin
                unique case (r_item.cmd)
                    CMD_PROBE: begin
                        if (tag_hit) begin
                            we          = out_free;
                            wentry.age  = r_age;
                            n_hit       = 1'b1;
                            n_hit_move  = rentry.move;
                            n_hit_score = adjust_score(rentry.score, r_item.ply, 1'b0,
                                                       i_mate_thr, i_mated_thr);
                            n_hit_depth = rentry.depth;
                            n_hit_flag  = rentry.flag;
                        end
                    end
                    CMD_STORE: begin
                        if (replace) begin
                            we           = out_free;
                            wentry.tag   = r_item.key;
                            wentry.age   = r_age;
                            wentry.flag  = r_item.flag;
                            wentry.depth = r_item.depth;
                            wentry.score = r_item.score;
                            wentry.move  = r_item.move;
                            n_stored     = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_clr_idx   <= '0;
            r_clr_pend  <= 1'b0;
            r_age       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_SWEEP: begin
                    r_clr_idx <= r_clr_idx + INDEX_BITS'(1);
                    if (r_clr_idx == {INDEX_BITS{1'b1}}) begin
                        r_age   <= 8'd0;
                        r_state <= r_clr_pend ? S_EXEC : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_head_valid) begin
                        r_item <= i_head;
                        if (i_head.cmd == CMD_CLEAR) begin
                            r_clr_idx  <= '0;
                            r_clr_pend <= 1'b1;
                            r_state    <= S_SWEEP;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_hit       <= n_hit;
                        r_hit_move  <= n_hit_move;
                        r_hit_score <= n_hit_score;
                        r_hit_depth <= n_hit_depth;
                        r_hit_flag  <= n_hit_flag;
                        r_stored    <= n_stored;
                        r_clr_pend  <= 1'b0;
                        if (r_item.cmd == CMD_NEW_GEN) begin
                            r_age <= r_age + 8'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_hit_move  = r_hit_move;
    assign o_hit_score = r_hit_score;
    assign o_hit_depth = r_hit_depth;
    assign o_hit_flag  = r_hit_flag;
    assign o_stored    = r_stored;

endmodule
